// File: hw/rtl/script_store_compactor_defines.svh
// Assertion macros shared by the script store compactor RTL.
`ifndef SCRIPT_STORE_COMPACTOR_DEFINES_SVH
`define SCRIPT_STORE_COMPACTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define SSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define SSC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SSC_ASSERT(label, prop, msg)
`define SSC_NEVER(label, cond, msg)
`endif

`endif

// File: hw/rtl/ssc_pkg.sv
// Types, sizes and codes shared by the script store compactor modules.
package ssc_pkg;

	localparam int SLOTS        = 32;
	localparam int BUFFER_BYTES = 1024;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [7:0]        byte_t;

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_HEADER = 3'd1;
	localparam logic [2:0] MODE_DATA   = 3'd2;
	localparam logic [2:0] MODE_CSUM   = 3'd3;
	localparam logic [2:0] MODE_LOCATE = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [7:0] MAX_LEN_RESET = 8'd61;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] slot;
		logic [7:0] length;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] length_sum;
		logic [15:0] byte_sum;
		logic [9:0]  start_index;
		logic [7:0]  script_length;
	} result_t;

	typedef logic [9:0] start_out_t;

	// Controller to datapath
	typedef struct packed {
		logic cap;
		logic exec;
		logic mv_step;
		logic commit;
		logic cs_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       hdr_ok;
		logic       step_done;
	} sts_t;

endpackage

// File: hw/rtl/ssc_ctrl.sv
// Sequencing state machine of the script store compactor.
`include "script_store_compactor_defines.svh"

module ssc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          out_load,
	output ssc_pkg::cmd_t cmd,
	input  ssc_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MOVE,
		S_COMMIT,
		S_CSUM,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd         = '0;
		cmd.cap     = (state_q == S_IDLE) && in_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.mv_step = (state_q == S_MOVE);
		cmd.commit  = (state_q == S_COMMIT);
		cmd.cs_step = (state_q == S_CSUM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (sts.mode == ssc_pkg::MODE_HEADER && sts.hdr_ok) begin
						state_q <= S_MOVE;
					end else if (sts.mode == ssc_pkg::MODE_CSUM) begin
						state_q <= S_CSUM;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MOVE: begin
					if (sts.step_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					state_q <= S_FIN;
				end
				S_CSUM: begin
					if (sts.step_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SSC_ASSERT(a_accept_execs, in_valid && !in_stall |=> state_q == S_EXEC, "accepted transaction did not execute")
	`SSC_ASSERT(a_fin_delivers, out_load |=> out_valid_q && state_q == S_IDLE, "finished result not presented")
	`SSC_NEVER(a_no_double_load, out_load && out_valid_q && out_stall, "result register overwritten")

endmodule

// File: hw/rtl/ssc_dp.sv
// Datapath of the script store compactor: byte store, slot table and sweep counters.
`include "script_store_compactor_defines.svh"

module ssc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  ssc_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  ssc_pkg::cmd_t    cmd,
	output ssc_pkg::sts_t    sts,
	output ssc_pkg::result_t res
);

	// Byte store, left unreset
	ssc_pkg::byte_t mem [ssc_pkg::BUFFER_BYTES];

	ssc_pkg::addr_t tbl_start_q [ssc_pkg::SLOTS];
	logic [7:0]     tbl_len_q   [ssc_pkg::SLOTS];

	ssc_pkg::item_t   item_q;
	ssc_pkg::result_t res_q;
	logic [7:0]       max_len_q;
	ssc_pkg::cnt_t    total_q;
	ssc_pkg::addr_t   ptr_q;
	logic [7:0]       pending_q;

	// Sweep state for gap closing and checksum
	ssc_pkg::cnt_t    rd_addr_q;
	ssc_pkg::addr_t   wr_addr_q;
	ssc_pkg::cnt_t    cnt_q;
	logic             rv_s1;
	ssc_pkg::byte_t   rdata_s1;
	logic [15:0]      acc_q;

	// Header operands kept for the commit step
	ssc_pkg::addr_t   s_q;
	logic [7:0]       gap_q;
	ssc_pkg::cnt_t    others_q;

	ssc_pkg::slot_idx_t idx;
	logic               slot_ok;
	logic [7:0]         cur_len;
	ssc_pkg::addr_t     cur_start;
	ssc_pkg::cnt_t      others;
	ssc_pkg::cnt_t      room;
	logic               hdr_ok;
	logic               step_done;
	logic               rd_en;
	logic               data_wr;
	logic               mem_we;
	ssc_pkg::addr_t     mem_waddr;
	ssc_pkg::byte_t     mem_wdata;

	assign idx       = item_q.slot[ssc_pkg::SLOT_W-1:0];
	assign slot_ok   = {1'b0, item_q.slot} < 9'(ssc_pkg::SLOTS);
	assign cur_len   = tbl_len_q[idx];
	assign cur_start = tbl_start_q[idx];
	assign others    = total_q - ssc_pkg::cnt_t'(cur_len);
	assign room      = ssc_pkg::cnt_t'(ssc_pkg::BUFFER_BYTES) - others;
	assign hdr_ok    = slot_ok && (item_q.length <= max_len_q)
		&& (others <= ssc_pkg::cnt_t'(ssc_pkg::BUFFER_BYTES))
		&& (ssc_pkg::cnt_t'(item_q.length) <= room);
	assign step_done = (cnt_q == '0) && !rv_s1;
	assign rd_en     = (cmd.mv_step || cmd.cs_step) && (cnt_q != '0);
	assign data_wr   = cmd.exec && (item_q.mode == ssc_pkg::MODE_DATA) && (pending_q != '0);

	assign mem_we    = data_wr || (cmd.mv_step && rv_s1);
	assign mem_waddr = cmd.mv_step ? wr_addr_q : ptr_q;
	assign mem_wdata = cmd.mv_step ? rdata_s1 : item_q.data_byte;

	always_comb begin
		sts           = '0;
		sts.mode      = item_q.mode;
		sts.hdr_ok    = hdr_ok;
		sts.step_done = step_done;
	end

	assign res = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr_q[ssc_pkg::ADDR_W-1:0]];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			res_q <= '0;
			case (item_q.mode)
				ssc_pkg::MODE_HEADER: begin
					s_q      <= cur_start;
					gap_q    <= cur_len;
					others_q <= others;
					if (!hdr_ok) begin
						res_q.status <= ssc_pkg::STATUS_FAIL;
					end
				end
				ssc_pkg::MODE_DATA: begin
					if (pending_q == '0) begin
						res_q.status <= ssc_pkg::STATUS_FAIL;
					end
				end
				ssc_pkg::MODE_CSUM: begin
					acc_q <= '0;
				end
				ssc_pkg::MODE_LOCATE: begin
					if (!slot_ok || cur_len == '0) begin
						res_q.status <= ssc_pkg::STATUS_EMPTY;
					end else begin
						res_q.start_index   <= ssc_pkg::start_out_t'(cur_start);
						res_q.script_length <= cur_len;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.commit) begin
			res_q <= '0;
		end
		if (cmd.cs_step) begin
			if (rv_s1) begin
				acc_q <= acc_q + 16'(rdata_s1);
			end
			if (step_done) begin
				res_q            <= '0;
				res_q.length_sum <= 16'(total_q);
				res_q.byte_sum   <= acc_q;
			end
		end
	end

	// Control state and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ssc_pkg::SLOTS; k++) begin
				tbl_start_q[k] <= '0;
				tbl_len_q[k]   <= '0;
			end
			max_len_q <= ssc_pkg::MAX_LEN_RESET;
			total_q   <= '0;
			ptr_q     <= '0;
			pending_q <= '0;
			rd_addr_q <= '0;
			wr_addr_q <= '0;
			cnt_q     <= '0;
			rv_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (cmd.exec) begin
				rv_s1 <= 1'b0;
				case (item_q.mode)
					ssc_pkg::MODE_CLEAR: begin
						for (int k = 0; k < ssc_pkg::SLOTS; k++) begin
							tbl_len_q[k] <= '0;
						end
						total_q   <= '0;
						ptr_q     <= '0;
						pending_q <= '0;
					end
					ssc_pkg::MODE_HEADER: begin
						pending_q <= '0;
						// Close the gap: read from start+gap, write from start
						rd_addr_q <= ssc_pkg::cnt_t'(cur_start) + ssc_pkg::cnt_t'(cur_len);
						wr_addr_q <= cur_start;
						cnt_q     <= (cur_len != '0) ? (others - ssc_pkg::cnt_t'(cur_start)) : '0;
					end
					ssc_pkg::MODE_DATA: begin
						if (pending_q != '0) begin
							ptr_q     <= ptr_q + 1'b1;
							pending_q <= pending_q - 1'b1;
						end
					end
					ssc_pkg::MODE_CSUM: begin
						rd_addr_q <= '0;
						cnt_q     <= total_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.mv_step || cmd.cs_step) begin
				rv_s1 <= rd_en;
				if (rd_en) begin
					rd_addr_q <= rd_addr_q + 1'b1;
					cnt_q     <= cnt_q - 1'b1;
				end
			end
			if (cmd.mv_step && rv_s1) begin
				wr_addr_q <= wr_addr_q + 1'b1;
			end
			if (cmd.commit) begin
				// Lower later starts, then place the slot at the end of the used region
				for (int k = 0; k < ssc_pkg::SLOTS; k++) begin
					if (tbl_len_q[k] != '0 && tbl_start_q[k] > s_q) begin
						tbl_start_q[k] <= tbl_start_q[k] - ssc_pkg::addr_t'(gap_q);
					end
				end
				tbl_len_q[idx]   <= item_q.length;
				tbl_start_q[idx] <= others_q[ssc_pkg::ADDR_W-1:0];
				ptr_q            <= others_q[ssc_pkg::ADDR_W-1:0];
				pending_q        <= item_q.length;
				total_q          <= others_q + ssc_pkg::cnt_t'(item_q.length);
			end
		end
	end

	`SSC_ASSERT(a_total_fits, total_q <= ssc_pkg::cnt_t'(ssc_pkg::BUFFER_BYTES), "used region exceeds store")
	`SSC_ASSERT(a_append_tiles, pending_q != '0 |-> ssc_pkg::cnt_t'(ptr_q) + ssc_pkg::cnt_t'(pending_q) == total_q, "append pointer out of step with used length")
	`SSC_ASSERT(a_move_order, cmd.mv_step && rv_s1 |-> ssc_pkg::cnt_t'(wr_addr_q) < rd_addr_q, "gap close writes ahead of reads")

endmodule

// File: hw/rtl/script_store_compactor.sv
// Top level of the script store compactor: controller, datapath and result register.
//
// Input channel (in_valid, in_stall, in_item) carries one command transaction per item:
// clear, store header, store data byte, checksum or locate. One result transaction leaves
// on the output channel (out_valid, out_stall, out_item) for every accepted transaction.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes max_script_length;
// cfg_ready is always high, and writes are meant for idle periods only.
//
// Each transaction is executed and its result then loaded into the output register; an
// accepted header first moves the bytes behind the old script down to close the gap and
// commits the slot table, and a checksum first sums every byte of the used region.
// The byte store has one read and one write per cycle, so gap closing and checksums move
// one byte per cycle. One transaction is worked on at a time; the next is taken in the cycle
// after the result has gone into the output register, even while that result still waits.
//
// Reset clears the slot table, the append pointer and the pending count and loads
// max_script_length with 61; the byte store is not cleared. While the receiver stalls,
// the result holds in the output register and a finished item waits in the controller.
module script_store_compactor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ssc_pkg::item_t   in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output ssc_pkg::result_t out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	ssc_pkg::cmd_t    cmd;
	ssc_pkg::sts_t    sts;
	ssc_pkg::result_t res;
	ssc_pkg::result_t out_q;
	logic             out_load;

	// Configuration writes always land at once
	assign cfg_ready = 1'b1;

	ssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_load  (out_load),
		.cmd       (cmd),
		.sts       (sts)
	);

	ssc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res)
	);

	// Output register: load the finished result, hold it while stalled
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_item = out_q;

endmodule

// File: bench/ssc_result_checker.sv
// Checker for the script store compactor: mirrors the store, predicts each result and compares.
`timescale 1ns / 1ps

module ssc_result_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  ssc_pkg::item_t   in_item,
	input  logic             out_valid,
	input  logic             out_stall,
	input  ssc_pkg::result_t out_item,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [7:0]       cfg_data,
	output int               fail_count,
	output int               results_due
);
	import ssc_pkg::*;

	byte_t   script_mem [BUFFER_BYTES];
	int      slot_base [SLOTS];
	int      slot_len [SLOTS];
	int      append_at;
	int      bytes_owed;
	int      len_limit;
	int      errors;
	int      n;
	result_t want;
	result_t replies_due [$];

	function automatic int used_total();
		int sum;
		int k;
		sum = 0;
		for (k = 0; k < SLOTS; k++)
			sum += slot_len[k];
		return sum;
	endfunction

	// Apply one command to the mirror and return the result it must produce.
	function automatic result_t store_command(item_t it);
		result_t r;
		int      all;
		int      others;
		int      base;
		int      gap;
		int      sum;
		int      s;
		int      k;
		r = '0;
		s = it.slot;
		case (it.mode)
			MODE_CLEAR: begin
				for (k = 0; k < SLOTS; k++)
					slot_len[k] = 0;
				bytes_owed = 0;
				append_at = 0;
			end
			MODE_HEADER: begin
				bytes_owed = 0;
				// slot is checked before the table is touched
				if (it.length > len_limit || s >= SLOTS) begin
					r.status = STATUS_FAIL;
				end else begin
					all = used_total();
					others = all - slot_len[s];
					if (it.length > BUFFER_BYTES - others) begin
						r.status = STATUS_FAIL;
					end else begin
						gap = slot_len[s];
						if (gap != 0) begin
							base = slot_base[s];
							for (k = base; k + gap < all && k + gap < BUFFER_BYTES; k++)
								script_mem[k] = script_mem[k + gap];
							for (k = 0; k < SLOTS; k++)
								if (slot_len[k] != 0 && slot_base[k] > base)
									slot_base[k] -= gap;
						end
						slot_len[s] = it.length;
						slot_base[s] = others;
						append_at = others;
						bytes_owed = it.length;
					end
				end
			end
			MODE_DATA: begin
				if (bytes_owed == 0) begin
					r.status = STATUS_FAIL;
				end else begin
					if (append_at < BUFFER_BYTES)
						script_mem[append_at] = it.data_byte;
					append_at++;
					bytes_owed--;
				end
			end
			MODE_CSUM: begin
				all = used_total();
				sum = 0;
				for (k = 0; k < all && k < BUFFER_BYTES; k++)
					sum += script_mem[k];
				r.length_sum = 16'(all);
				r.byte_sum = 16'(sum);
			end
			MODE_LOCATE: begin
				if (s >= SLOTS || slot_len[s] == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.start_index = 10'(slot_base[s]);
					r.script_length = 8'(slot_len[s]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (n = 0; n < BUFFER_BYTES; n++)
				script_mem[n] = '0;
			for (n = 0; n < SLOTS; n++) begin
				slot_base[n] = 0;
				slot_len[n] = 0;
			end
			append_at = 0;
			bytes_owed = 0;
			len_limit = MAX_LEN_RESET;
			errors = 0;
			replies_due.delete();
			fail_count <= 0;
			results_due <= 0;
		end else begin
			// results leaving now belong to older commands: retire them first
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: result with none outstanding: st=%0d ls=%h bs=%h at=%0d len=%0d",
							$realtime, out_item.status, out_item.length_sum, out_item.byte_sum,
							out_item.start_index, out_item.script_length);
				end else begin
					want = replies_due.pop_front();
					if (out_item.status !== want.status
							|| out_item.length_sum !== want.length_sum
							|| out_item.byte_sum !== want.byte_sum
							|| out_item.start_index !== want.start_index
							|| out_item.script_length !== want.script_length) begin
						errors++;
						if (errors <= 10)
							$display("%t: mismatch: want st=%0d ls=%h bs=%h at=%0d len=%0d, got st=%0d ls=%h bs=%h at=%0d len=%0d",
								$realtime, want.status, want.length_sum, want.byte_sum,
								want.start_index, want.script_length,
								out_item.status, out_item.length_sum, out_item.byte_sum,
								out_item.start_index, out_item.script_length);
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(store_command(in_item));
			if (cfg_valid && cfg_ready)
				len_limit = cfg_data;
			fail_count <= errors;
			results_due <= replies_due.size();
		end
	end

endmodule

// File: bench/tb.sv
// Testbench top for the script store compactor: stimulus, idling and the final verdict.
`timescale 1ns / 1ps

module tb;
	import ssc_pkg::*;

	// Modes past locate are unused; the block must leave its state alone for them.
	localparam logic [2:0] MODE_UNUSED_FIRST = MODE_LOCATE + 3'd1;

	// Slowest legal run: about 500 transactions, each in the worst case a checksum or a gap
	// close over the full 1024-byte store plus the longest drawn idle gap on either side.
	// CYCLE_LIMIT is set to several times that.
	localparam int CYCLE_LIMIT = 4_000_000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	item_t      in_item = '0;
	logic       out_stall = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       in_stall;
	logic       out_valid;
	logic       cfg_ready;
	result_t    out_item;
	int         fail_count;
	int         results_due;

	int          items_sent = 0;
	int          cycle_count = 0;
	int unsigned limit_now = MAX_LEN_RESET;
	int unsigned stall_left = 0;
	int unsigned hold;
	bit          calm = 1'b0;

	script_store_compactor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ssc_result_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Idle length for the next transaction on either side; zero throughout a calm stretch.
	function automatic int unsigned draw_wait();
		if (calm)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic byte_t r8();
		return 8'($urandom);
	endfunction

	// Favour a few low slots so that scripts get replaced often; now and then an
	// out-of-range slot.
	function automatic byte_t pick_slot();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 8'($urandom_range(0, 7));
		if (pick < 90)
			return 8'($urandom_range(0, SLOTS - 1));
		return 8'($urandom_range(SLOTS, 255));
	endfunction

	// Mostly short scripts to keep gap closing cheap; sometimes the limit, zero or beyond.
	function automatic int unsigned pick_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return $urandom_range(1, (limit_now < 16) ? limit_now : 16);
		if (pick < 80)
			return $urandom_range(0, limit_now);
		if (pick < 90)
			return limit_now;
		if (limit_now < 255)
			return $urandom_range(limit_now + 1, 255);
		return $urandom_range(0, 255);
	endfunction

	// Receiver: after each transaction taken, hold stall for a drawn number of cycles
	// in which a result is actually waiting.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold = draw_wait();
			stall_left <= hold;
			out_stall <= (hold != 0);
		end else if (out_valid && stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (out_valid) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	// Offer one command and return at the edge where the transaction is taken.
	// Valid stays high when the next command follows without a gap.
	task automatic send(input logic [2:0] mode, input byte_t slot, input byte_t length,
			input byte_t data_byte);
		int unsigned gap;
		item_t       it;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.mode = mode;
		it.slot = slot;
		it.length = length;
		it.data_byte = data_byte;
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// Drop valid and hold until every outstanding result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input int unsigned value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= 8'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	// Directed cases from an empty store. Every byte that a checksum or a gap close reads
	// has been written: an unfinished script is emptied before anything reads it.
	task automatic directed();
		int k;
		send(MODE_CSUM, r8(), r8(), r8());                 // checksum of an empty store
		send(MODE_HEADER, 8'd0, 8'd4, r8());
		for (k = 0; k < 4; k++)
			send(MODE_DATA, r8(), r8(), r8());
		send(MODE_HEADER, 8'd1, 8'd5, r8());
		send(MODE_DATA, r8(), r8(), 8'h00);
		send(MODE_DATA, r8(), r8(), 8'hFF);
		for (k = 0; k < 3; k++)
			send(MODE_DATA, r8(), r8(), r8());
		send(MODE_HEADER, 8'd2, 8'd3, r8());
		for (k = 0; k < 3; k++)
			send(MODE_DATA, r8(), r8(), r8());
		send(MODE_CSUM, r8(), r8(), r8());
		send(MODE_HEADER, 8'd1, 8'd2, r8());               // replace: close a gap mid-store
		send(MODE_DATA, r8(), r8(), 8'h00);
		send(MODE_DATA, r8(), r8(), 8'hFF);
		send(MODE_DATA, r8(), r8(), r8());                 // surplus data byte
		send(MODE_LOCATE, 8'd1, r8(), r8());
		send(MODE_LOCATE, 8'd2, r8(), r8());               // start lowered by the gap
		send(MODE_LOCATE, 8'd31, r8(), r8());              // never used slot
		send(MODE_LOCATE, 8'hFF, r8(), r8());              // slot out of range
		send(MODE_HEADER, 8'(SLOTS), 8'd5, r8());          // first invalid slot
		send(MODE_HEADER, 8'hFF, 8'd5, r8());
		send(MODE_HEADER, 8'd5, 8'hFF, r8());              // above the length limit
		send(MODE_HEADER, 8'd0, 8'd0, r8());               // zero length empties slot 0
		send(MODE_CSUM, r8(), r8(), r8());
		send(MODE_UNUSED_FIRST, r8(), r8(), r8());
		send(MODE_UNUSED_FIRST + 3'd1, r8(), r8(), r8());
		send(MODE_UNUSED_FIRST + 3'd2, r8(), r8(), r8());
		send(MODE_HEADER, 8'd31, 8'd61, r8());             // exactly the limit
		send(MODE_DATA, r8(), r8(), r8());
		send(MODE_HEADER, 8'd31, 8'd0, r8());              // drop the unfinished script
		send(MODE_DATA, r8(), r8(), r8());                 // nothing pending any more
		send(MODE_CSUM, r8(), r8(), r8());
		send(MODE_CLEAR, r8(), r8(), r8());
		send(MODE_CSUM, r8(), r8(), r8());
	endtask

	// With the limit at 255, four headers without data leave 4 bytes of room. None of
	// their bytes is read: the slots start empty, so nothing moves, and a clear follows.
	task automatic room_check();
		int s;
		send(MODE_CLEAR, r8(), r8(), r8());
		for (s = 0; s < 4; s++)
			send(MODE_HEADER, 8'(s), 8'd255, r8());
		send(MODE_HEADER, 8'd4, 8'd5, r8());               // too little room left
		send(MODE_HEADER, 8'd4, 8'd4, r8());               // exactly fills the store
		send(MODE_HEADER, 8'd5, 8'd1, r8());               // no room at all
		send(MODE_HEADER, 8'd5, 8'd0, r8());               // zero length still fits
		send(MODE_LOCATE, 8'd4, r8(), r8());
		send(MODE_LOCATE, 8'd5, r8(), r8());
		send(MODE_CLEAR, r8(), r8(), r8());
	endtask

	// Mostly headers followed by their data bytes, now and then interleaved with locates
	// or cut short; the rest is queries, stray bytes, unused modes, bad headers and clears.
	// A script cut short is the last one in the store: empty it at once, so that no
	// checksum or gap close ever reads a byte that was never written.
	task automatic random_phase(input int quota);
		int          first;
		int unsigned left;
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		int unsigned k;
		byte_t       slot;
		first = items_sent;
		while (items_sent - first < quota) begin
			left = quota - (items_sent - first);
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = pick_length();
				if (len > limit_now)
					cut = $urandom_range(0, 3);
				else if ($urandom_range(0, 11) == 0)
					cut = $urandom_range(0, len);
				else
					cut = len;
				if (cut >= left)
					cut = left - 1;
				slot = pick_slot();
				send(MODE_HEADER, slot, 8'(len), r8());
				for (k = 0; k < cut; k++) begin
					if ($urandom_range(0, 9) == 0)
						send(MODE_LOCATE, pick_slot(), r8(), r8());
					send(MODE_DATA, r8(), r8(), r8());
				end
				if (cut < len)
					send(MODE_HEADER, slot, 8'd0, r8());
			end else if (pick < 70) begin
				send(MODE_CSUM, r8(), r8(), r8());
			end else if (pick < 85) begin
				send(MODE_LOCATE, pick_slot(), r8(), r8());
			end else if (pick < 90) begin
				send(MODE_DATA, r8(), r8(), r8());
			end else if (pick < 94) begin
				send(MODE_UNUSED_FIRST + 3'($urandom_range(0, 2)), r8(), r8(), r8());
			end else if (pick < 97) begin
				slot = pick_slot();
				send(MODE_HEADER, slot, r8(), r8());
				send(MODE_HEADER, slot, 8'd0, r8());
			end else begin
				send(MODE_CLEAR, r8(), r8(), r8());
			end
		end
	endtask

	initial begin
		// hold reset, then release it on an edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		// advance through the limit settings: both extremes, one with bit 0 clear, one drawn
		write_limit(255);
		room_check();
		random_phase(110);
		write_limit(1);
		random_phase(110);
		write_limit(130);
		random_phase(110);
		write_limit($urandom_range(2, 254));
		random_phase(110);

		// drain, then leave room for any stray result to show up
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
